[rtl/core/assert_macros.svh]
// Assertion macros used by otpb_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property outside reset
`define OTPB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define OTPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/otpb_pkg.sv]
// Shared types, codes and the quadrant mix table of the tile pixel blend.
// No dependencies.
`default_nettype none
package otpb_pkg;
    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam int NUM_W = 14;
    localparam int RGB_W = 24;
    localparam int CH_W  = 8;
    localparam int NCH   = 3;
    localparam int NLANE = 5;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_POS    = 2'd2;

    localparam logic [3:0] CLS_INTERIOR = 4'd0;
    localparam logic [3:0] CLS_TOP      = 4'd1;
    localparam logic [3:0] CLS_BOTTOM   = 4'd2;
    localparam logic [3:0] CLS_LEFT     = 4'd3;
    localparam logic [3:0] CLS_RIGHT    = 4'd4;
    localparam logic [3:0] CLS_TL       = 4'd5;
    localparam logic [3:0] CLS_TR       = 4'd6;
    localparam logic [3:0] CLS_BL       = 4'd7;
    localparam logic [3:0] CLS_BR       = 4'd8;

    localparam logic [1:0] Q_TL = 2'd0;
    localparam logic [1:0] Q_TR = 2'd1;
    localparam logic [1:0] Q_BL = 2'd2;
    localparam logic [1:0] Q_BR = 2'd3;

    typedef enum logic [2:0] {
        K_DIAG, K_MID_LEFT_H, K_MID_RIGHT_H, K_TOP_MID, K_BOT_MID,
        K_MID_RIGHT_C, K_MID_LEFT_C, K_ALONE
    } t_kind;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } t_ratio;

    typedef struct packed {
        logic             alone;
        logic [RGB_W-1:0] pm;
        logic [RGB_W-1:0] px;
        logic [RGB_W-1:0] py;
    } t_pix;

    function automatic t_kind quad_kind(input logic [3:0] cls, input logic [1:0] quad);
        t_kind k;
        k = K_DIAG;
        case (cls)
            CLS_TOP: begin
                if (quad == Q_TL) k = K_MID_LEFT_H;
                else if (quad == Q_TR) k = K_MID_RIGHT_H;
            end
            CLS_BOTTOM: begin
                if (quad == Q_BL) k = K_MID_LEFT_H;
                else if (quad == Q_BR) k = K_MID_RIGHT_H;
            end
            CLS_LEFT: begin
                if (quad == Q_TL) k = K_TOP_MID;
                else if (quad == Q_BL) k = K_BOT_MID;
            end
            CLS_RIGHT: begin
                if (quad == Q_TR) k = K_TOP_MID;
                else if (quad == Q_BR) k = K_BOT_MID;
            end
            CLS_TL: begin
                if (quad == Q_TL) k = K_ALONE;
                else if (quad == Q_TR) k = K_MID_RIGHT_C;
                else if (quad == Q_BL) k = K_BOT_MID;
            end
            CLS_TR: begin
                if (quad == Q_TL) k = K_MID_LEFT_C;
                else if (quad == Q_TR) k = K_ALONE;
                else if (quad == Q_BR) k = K_BOT_MID;
            end
            CLS_BL: begin
                if (quad == Q_TL) k = K_TOP_MID;
                else if (quad == Q_BL) k = K_ALONE;
                else if (quad == Q_BR) k = K_MID_RIGHT_C;
            end
            CLS_BR: begin
                if (quad == Q_TR) k = K_TOP_MID;
                else if (quad == Q_BL) k = K_MID_LEFT_C;
                else if (quad == Q_BR) k = K_ALONE;
            end
            default: k = K_DIAG;
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

[rtl/core/otpb_front.sv]
// Front stage: clamp sizes, classify quadrant, form the five ratio operands.
// Depends on otpb_pkg.
`default_nettype none
module otpb_front import otpb_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DIM_W-1:0] i_height,
    input  wire logic [DIM_W-1:0] i_width,
    input  wire logic [3:0]       i_pos,
    input  wire logic [POS_W-1:0] i_row,
    input  wire logic [POS_W-1:0] i_col,
    input  wire logic [RGB_W-1:0] i_mid,
    input  wire logic [RGB_W-1:0] i_top,
    input  wire logic [RGB_W-1:0] i_left,
    input  wire logic [RGB_W-1:0] i_right,
    input  wire logic [RGB_W-1:0] i_bottom,
    output t_ratio                o_ratio [NLANE],
    output t_pix                  o_pix
);
    t_ratio r_ratio [NLANE];
    t_pix   r_pix;
    t_ratio n_ratio [NLANE];
    t_pix   n_pix;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = d;
        if (d < DIM_W'(2)) c = DIM_W'(2);
        else if (32'(d) > 32'(MAX_DIM)) c = DIM_W'(MAX_DIM);
        return c;
    endfunction

    always_comb begin
        logic [DIM_W-1:0] hc, wc, dr, db;
        logic [POS_W-1:0] m, n;
        logic             bot, rgt;
        logic [1:0]       quad;
        t_kind            kind;
        logic [NUM_W-1:0] rowx, colx, drx, dbx, mx, nx;
        hc = clamp_dim(i_height);
        wc = clamp_dim(i_width);
        m = hc[DIM_W-1:1];
        n = wc[DIM_W-1:1];
        dr = (wc > {1'b0, i_col}) ? wc - {1'b0, i_col} : '0;
        db = (hc > {1'b0, i_row}) ? hc - {1'b0, i_row} : '0;
        bot = !(i_row < m);
        rgt = !(i_col < n);
        quad = {bot, rgt};
        kind = quad_kind(i_pos, quad);
        rowx = NUM_W'(i_row);
        colx = NUM_W'(i_col);
        drx = NUM_W'(dr);
        dbx = NUM_W'(db);
        mx = NUM_W'(m);
        nx = NUM_W'(n);
        n_ratio[0] = '{num: colx, den: nx};
        n_ratio[1] = '{num: rowx, den: mx};
        n_ratio[2] = '{num: drx, den: nx};
        n_ratio[3] = '{num: dbx, den: mx};
        n_ratio[4] = '{num: '0, den: '0};
        n_pix.alone = 1'b0;
        n_pix.pm = i_mid;
        n_pix.px = '0;
        n_pix.py = '0;
        case (kind)
            K_DIAG: begin
                n_pix.px = bot ? i_bottom : i_top;
                n_pix.py = rgt ? i_right : i_left;
                n_ratio[4].num = rgt ? drx : colx;
                n_ratio[4].den = (bot ? dbx : rowx) + (rgt ? drx : colx);
            end
            K_MID_LEFT_H: begin
                n_pix.px = i_mid;
                n_pix.py = i_left;
                n_ratio[4].num = (nx > colx) ? nx - colx : '0;
                n_ratio[4].den = nx;
            end
            K_MID_RIGHT_H: begin
                n_pix.px = i_mid;
                n_pix.py = i_right;
                n_ratio[4].num = (colx > nx) ? colx - nx : '0;
                n_ratio[4].den = nx;
            end
            K_TOP_MID: begin
                n_pix.px = i_top;
                n_pix.py = i_mid;
                n_ratio[4].num = (mx > rowx) ? mx - rowx : '0;
                n_ratio[4].den = mx;
            end
            K_BOT_MID: begin
                n_pix.px = i_bottom;
                n_pix.py = i_mid;
                n_ratio[4].num = (rowx > mx) ? rowx - mx : '0;
                n_ratio[4].den = mx;
            end
            K_MID_RIGHT_C: begin
                n_pix.px = i_mid;
                n_pix.py = i_right;
                n_ratio[4].num = drx;
                n_ratio[4].den = nx;
            end
            K_MID_LEFT_C: begin
                n_pix.px = i_mid;
                n_pix.py = i_left;
                n_ratio[4].num = colx;
                n_ratio[4].den = nx;
            end
            default: n_pix.alone = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ratio <= n_ratio;
            r_pix <= n_pix;
        end
    end

    assign o_ratio = r_ratio;
    assign o_pix = r_pix;
endmodule
`default_nettype wire

[rtl/core/otpb_div.sv]
// Pipelined restoring divider, one quotient bit per stage on five lanes.
// Depends on otpb_pkg.
`default_nettype none
module otpb_div import otpb_pkg::*; #(
    parameter int F = 16
) (
    input  wire logic         i_clk,
    input  wire logic [F-1:0] i_en,
    input  t_ratio            i_ratio [NLANE],
    output logic [F:0]        o_q [NLANE]
);
    localparam int REM_W = NUM_W + F;
    localparam logic [F:0] W_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] W_HALF = {2'b01, {(F-1){1'b0}}};

    logic [REM_W-1:0] rem_in  [F][NLANE];
    logic [NUM_W-1:0] den_in  [F][NLANE];
    logic [F-1:0]     q_in    [F][NLANE];
    logic             half_in [F][NLANE];
    logic             one_in  [F][NLANE];
    logic [REM_W-1:0] r_rem   [F][NLANE];
    logic [NUM_W-1:0] r_den   [F][NLANE];
    logic [F-1:0]     r_q     [F][NLANE];
    logic             r_half  [F][NLANE];
    logic             r_one   [F][NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            rem_in[0][l] = {i_ratio[l].num, {F{1'b0}}} + REM_W'(i_ratio[l].den >> 1);
            den_in[0][l] = i_ratio[l].den;
            q_in[0][l] = '0;
            half_in[0][l] = (i_ratio[l].den == '0);
            one_in[0][l] = (rem_in[0][l] >= {i_ratio[l].den, {F{1'b0}}});
        end
    end

    for (genvar s = 1; s < F; s++) begin : g_link
        always_comb begin
            for (int l = 0; l < NLANE; l++) begin
                rem_in[s][l] = r_rem[s-1][l];
                den_in[s][l] = r_den[s-1][l];
                q_in[s][l] = r_q[s-1][l];
                half_in[s][l] = r_half[s-1][l];
                one_in[s][l] = r_one[s-1][l];
            end
        end
    end

    for (genvar s = 0; s < F; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                for (int l = 0; l < NLANE; l++) begin
                    if (rem_in[s][l] >= (REM_W'(den_in[s][l]) << (F - 1 - s))) begin
                        r_rem[s][l] <= rem_in[s][l] - (REM_W'(den_in[s][l]) << (F - 1 - s));
                        r_q[s][l] <= q_in[s][l] | (F'(1) << (F - 1 - s));
                    end else begin
                        r_rem[s][l] <= rem_in[s][l];
                        r_q[s][l] <= q_in[s][l];
                    end
                    r_den[s][l] <= den_in[s][l];
                    r_half[s][l] <= half_in[s][l];
                    r_one[s][l] <= one_in[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (r_half[F-1][l]) o_q[l] = W_HALF;
            else if (r_one[F-1][l]) o_q[l] = W_ONE;
            else o_q[l] = {1'b0, r_q[F-1][l]};
        end
    end
endmodule
`default_nettype wire

[rtl/core/otpb_mix.sv]
// Weight select and per-channel rounded blend over three stages.
// Depends on otpb_pkg.
`default_nettype none
module otpb_mix import otpb_pkg::*; #(
    parameter int F = 16
) (
    input  wire logic         i_clk,
    input  wire logic [2:0]   i_en,
    input  wire logic [F:0]   i_q [NLANE],
    input  t_pix              i_pix,
    output logic [RGB_W-1:0]  o_rgb
);
    localparam logic [F:0]   W_ONE = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0] HALFR = {1'b1, {(F-1){1'b0}}};

    logic [F:0]      r1_wm, r1_wc, r1_t, r1_omt;
    t_pix            r1_pix;
    logic [CH_W-1:0] r2_a [NCH];
    logic [CH_W-1:0] r2_s [NCH];
    logic [F:0]      r2_wc;
    logic [RGB_W-1:0] r3_rgb;
    logic [F:0]      n_wm;

    function automatic logic [CH_W-1:0] mulw(input logic [CH_W-1:0] v, input logic [F:0] w);
        logic [F+8:0]  p;
        logic [8:0]    qv;
        logic [F-1:0]  rr;
        logic          inc;
        logic [9:0]    qs;
        p = (F+9)'(v) * (F+9)'(w);
        qv = p[F+8:F];
        rr = p[F-1:0];
        inc = (rr > HALFR) || ((rr == HALFR) && qv[0]);
        qs = {1'b0, qv} + 10'(inc);
        return (qs > 10'd255) ? 8'hFF : qs[7:0];
    endfunction

    function automatic logic [CH_W-1:0] sat8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        logic [CH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CH_W] ? 8'hFF : s[CH_W-1:0];
    endfunction

    always_comb begin
        logic [F:0] m01, m23;
        m01 = (i_q[1] < i_q[0]) ? i_q[1] : i_q[0];
        m23 = (i_q[3] < i_q[2]) ? i_q[3] : i_q[2];
        n_wm = (m23 < m01) ? m23 : m01;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_wm <= n_wm;
            r1_wc <= W_ONE - n_wm;
            r1_t <= i_q[4];
            r1_omt <= W_ONE - i_q[4];
            r1_pix <= i_pix;
        end
        if (i_en[1]) begin
            for (int k = 0; k < NCH; k++) begin
                r2_a[k] <= mulw(r1_pix.pm[8*k +: 8], r1_wm);
                r2_s[k] <= r1_pix.alone ? r1_pix.pm[8*k +: 8]
                         : sat8(mulw(r1_pix.px[8*k +: 8], r1_t),
                                mulw(r1_pix.py[8*k +: 8], r1_omt));
            end
            r2_wc <= r1_wc;
        end
        if (i_en[2]) begin
            for (int k = 0; k < NCH; k++) begin
                r3_rgb[8*k +: 8] <= sat8(r2_a[k], mulw(r2_s[k], r2_wc));
            end
        end
    end

    assign o_rgb = r3_rgb;
endmodule
`default_nettype wire

[rtl/core/overlap_tile_pixel_blend.sv]
// Throughput: one word per cycle while the output is not stalled;
// the divider retires one quotient bit per stage.
// Stages advance independently, so bubbles close up while the output is stalled.
// Reset: synchronous, clears all valid bits; height and width 512, tile position 0.
// Depends on otpb_pkg, otpb_front, otpb_div, otpb_mix.
`default_nettype none
module overlap_tile_pixel_blend import otpb_pkg::*; #(
    parameter int MAX_DIM          = 4096,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [POS_W-1:0] i_pixel_row,
    input  wire logic [POS_W-1:0] i_pixel_col,
    input  wire logic [RGB_W-1:0] i_mid_rgb,
    input  wire logic [RGB_W-1:0] i_top_rgb,
    input  wire logic [RGB_W-1:0] i_left_rgb,
    input  wire logic [RGB_W-1:0] i_right_rgb,
    input  wire logic [RGB_W-1:0] i_bottom_rgb,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [RGB_W-1:0]      o_blended_rgb
);
    localparam int F = WEIGHT_FRAC_BITS;
    localparam int S = F + 4;

    logic [DIM_W-1:0] r_height, r_width;
    logic [3:0]       r_pos;
    logic [S-1:0]     r_v;
    logic [S-1:0]     en;
    t_ratio           ratio [NLANE];
    t_pix             front_pix;
    t_pix             r_pix_d [F];
    logic [F:0]       q [NLANE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= DIM_W'(512);
            r_width <= DIM_W'(512);
            r_pos <= CLS_INTERIOR;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_WIDTH:  r_width <= pwdata[DIM_W-1:0];
                REG_POS:    r_pos <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HEIGHT: prdata = 32'(r_height);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_POS:    prdata = 32'(r_pos);
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    always_comb begin
        en[S-1] = !r_v[S-1] || !i_stall;
        for (int k = S - 2; k >= 0; k--) en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < S; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) r_pix_d[0] <= front_pix;
        for (int k = 1; k < F; k++) begin
            if (en[k+1]) r_pix_d[k] <= r_pix_d[k-1];
        end
    end

    otpb_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk    (i_clk),
        .i_en     (en[0]),
        .i_height (r_height),
        .i_width  (r_width),
        .i_pos    (r_pos),
        .i_row    (i_pixel_row),
        .i_col    (i_pixel_col),
        .i_mid    (i_mid_rgb),
        .i_top    (i_top_rgb),
        .i_left   (i_left_rgb),
        .i_right  (i_right_rgb),
        .i_bottom (i_bottom_rgb),
        .o_ratio  (ratio),
        .o_pix    (front_pix)
    );

    otpb_div #(.F(F)) u_div (
        .i_clk   (i_clk),
        .i_en    (en[F:1]),
        .i_ratio (ratio),
        .o_q     (q)
    );

    otpb_mix #(.F(F)) u_mix (
        .i_clk (i_clk),
        .i_en  (en[F+3:F+1]),
        .i_q   (q),
        .i_pix (r_pix_d[F-1]),
        .o_rgb (o_blended_rgb)
    );

    assign o_stall = !en[0];
    assign o_valid = r_v[S-1];
endmodule
`default_nettype wire

[rtl/core/otpb_checker.sv]
// Port-level checker for the tile pixel blend, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module otpb_sva (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_blended_rgb,
    input wire logic        pready
);
    `OTPB_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_blended_rgb), "stalled result word changed")
    `OTPB_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled without output backpressure")
    `OTPB_ASSERT(a_pready, i_clk, i_rst_n, pready, "pready dropped")
    `OTPB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "pipeline not empty after reset")
endmodule

bind overlap_tile_pixel_blend otpb_sva u_otpb_sva (.*);
`default_nettype wire
